// ===== sv/rau_pkg.sv =====
// Package: payload types and operation codes for the rational arithmetic unit.
package rau_pkg;
    localparam int unsigned FieldBits = 32;

    typedef enum logic [2:0] {
        FUNC_ADD = 3'd0,
        FUNC_SUB = 3'd1,
        FUNC_MUL = 3'd2,
        FUNC_DIV = 3'd3,
        FUNC_NEG = 3'd4,
        FUNC_INC = 3'd5,
        FUNC_DEC = 3'd6,
        FUNC_CMP = 3'd7
    } t_func;

    typedef struct packed {
        logic [2:0]                  func;
        logic signed [FieldBits-1:0] a_num;
        logic signed [FieldBits-1:0] a_den;
        logic signed [FieldBits-1:0] b_num;
        logic signed [FieldBits-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [FieldBits-1:0] res_num;
        logic signed [FieldBits-1:0] res_den;
        logic                        a_greater;
        logic                        a_less;
        logic                        fields_equal;
        logic                        a_is_zero;
        logic                        overflow;
    } t_out;
endpackage

// ===== sv/rau_divider.sv =====
// Module: shared iterative signed divider, truncating quotient and remainder.
module rau_divider #(
    parameter int unsigned W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    output logic                o_done,
    output logic signed [W-1:0] o_quo,
    output logic signed [W-1:0] o_rem
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_q;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_qneg;
    logic          r_rneg;
    logic          r_done;
    logic [W:0]    w_sh;
    logic [W:0]    w_sub;

    // Restoring shift-subtract, one quotient bit per cycle on magnitudes.
    assign w_sh  = {r_r, r_q[W-1]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_q    <= i_x[W-1] ? W'(-i_x) : i_x;
                r_d    <= i_y[W-1] ? W'(-i_y) : i_y;
                r_r    <= '0;
                r_qneg <= i_x[W-1] ^ i_y[W-1];
                r_rneg <= i_x[W-1];
            end else if (r_busy) begin
                if (!w_sub[W]) begin
                    r_r <= w_sub[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= w_sh[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_qneg ? -$signed(r_q) : $signed(r_q);
    assign o_rem  = r_rneg ? -$signed(r_r) : $signed(r_r);
endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// Top level: rational arithmetic unit with Euclid gcd reduction.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------
//  input   | in        | i_valid / o_ready  | i_data (t_in)
//  result  | out       | o_valid / i_ready  | o_data (t_out)
//
// One transfer at a time. Products and compare products come from one
// multiplier over steps S_M0 to S_M3; each Euclid remainder and each final
// division uses the shared divider. Worst case about 46 remainder steps plus
// two divisions; inc, dec and compare skip the reduction and the divisions.
// Reset is synchronous, active low, and clears the sequencer.
// A stalled result holds in o_data while the next item is taken and worked;
// that item's result then waits in the sequencer until o_data is free.
module rational_arithmetic_unit #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rau_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output rau_pkg::t_out o_data
);
    localparam int unsigned W  = WORD_BITS;
    localparam int unsigned FB = rau_pkg::FieldBits;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_SUM,
        S_GCD, S_GWAIT, S_DN, S_DNW, S_DD, S_DDW, S_OUT
    } t_state;

    t_state              r_state;
    logic [2:0]          r_func;
    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [W-1:0] r_p, r_q, r_rn, r_rd;
    logic signed [W-1:0] r_gx, r_gy;
    logic                r_gt, r_lt, r_ovf;
    logic                r_valid;
    rau_pkg::t_out       r_out;

    // Shared multiplier: operands chosen per sequencer step.
    logic signed [W-1:0]   w_ma, w_mb;
    logic signed [2*W-1:0] w_prod;
    logic signed [W-1:0]   w_plo;
    logic                  w_pov;
    logic signed [2*W-1:0] r_lhs;

    logic                d_start, d_done;
    logic signed [W-1:0] d_x, d_y, d_quo, d_rem;

    logic signed [W-1:0] w_an, w_ad, w_bn, w_bd;
    logic signed [W:0]   w_sum;
    logic                w_add;

    assign w_an = i_data.a_num[W-1:0];
    assign w_ad = (i_data.a_den[W-1:0] == '0) ? W'(1) : i_data.a_den[W-1:0];
    assign w_bn = i_data.b_num[W-1:0];
    assign w_bd = (i_data.b_den[W-1:0] == '0) ? W'(1) : i_data.b_den[W-1:0];

    always_comb begin
        case (r_state)
            S_M0:    begin w_ma = r_an; w_mb = r_bd; end
            S_M1:    begin w_ma = r_bn; w_mb = r_ad; end
            S_M2:    begin w_ma = r_ad; w_mb = r_bd; end
            S_M3:    begin w_ma = r_an; w_mb = r_bn; end
            default: begin w_ma = r_an; w_mb = r_bd; end
        endcase
    end
    assign w_prod = w_ma * w_mb;
    assign w_plo  = w_prod[W-1:0];
    assign w_pov  = (2*W)'(w_plo) != w_prod;

    // Add or subtract of the two cross products (a_num and a_den for inc/dec), with exact overflow check.
    assign w_add = (r_func == rau_pkg::FUNC_ADD) || (r_func == rau_pkg::FUNC_INC);
    assign w_sum = w_add ? ((W+1)'(r_p) + (W+1)'(r_q)) : ((W+1)'(r_p) - (W+1)'(r_q));

    assign d_start = (r_state == S_GCD) || (r_state == S_DN) || (r_state == S_DD);
    assign d_x = (r_state == S_DN) ? r_rn : (r_state == S_DD) ? r_rd : r_gx;
    assign d_y = r_gx;

    rau_divider #(.W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (d_start && !(r_state == S_GCD && r_gy == W'(-1))),
        .i_x     ((r_state == S_GCD) ? r_gx : d_x),
        .i_y     ((r_state == S_GCD) ? r_gy : d_y),
        .o_done  (d_done),
        .o_quo   (d_quo),
        .o_rem   (d_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            // S_OUT drives r_valid itself when it loads a result.
            if (r_valid && i_ready && (r_state != S_OUT)) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= i_data.func;
                        r_an    <= w_an;
                        r_ad    <= w_ad;
                        r_bn    <= w_bn;
                        r_bd    <= w_bd;
                        r_ovf   <= 1'b0;
                        r_state <= S_M0;
                    end
                end
                S_M0: begin
                    r_lhs <= w_prod;
                    r_p   <= w_plo;
                    if (r_func == rau_pkg::FUNC_ADD || r_func == rau_pkg::FUNC_SUB ||
                        r_func == rau_pkg::FUNC_DIV) r_ovf <= w_pov;
                    r_state <= S_M1;
                end
                S_M1: begin
                    // Exact compare on the full products.
                    if ((r_ad[W-1]) == (r_bd[W-1])) begin
                        r_gt <= r_lhs > w_prod;
                        r_lt <= r_lhs < w_prod;
                    end else begin
                        r_gt <= r_lhs < w_prod;
                        r_lt <= r_lhs > w_prod;
                    end
                    r_q <= w_plo;
                    if (r_func == rau_pkg::FUNC_ADD || r_func == rau_pkg::FUNC_SUB ||
                        r_func == rau_pkg::FUNC_DIV) begin
                        if (w_pov) r_ovf <= 1'b1;
                    end
                    r_state <= S_M2;
                end
                S_M2: begin
                    if (r_func == rau_pkg::FUNC_ADD || r_func == rau_pkg::FUNC_SUB ||
                        r_func == rau_pkg::FUNC_MUL) begin
                        r_rd <= (w_plo == '0) ? W'(1) : w_plo;
                        if (w_pov) r_ovf <= 1'b1;
                    end
                    r_state <= S_M3;
                end
                S_M3: begin
                    if (r_func == rau_pkg::FUNC_MUL) begin
                        r_rn <= w_plo;
                        if (w_pov) r_ovf <= 1'b1;
                    end
                    r_state <= S_M4;
                end
                S_M4: begin
                    // Per-operation setup of numerator/denominator.
                    case (r_func)
                        rau_pkg::FUNC_DIV: begin
                            r_rn <= r_p;
                            r_rd <= (r_q == '0) ? W'(1) : r_q;
                        end
                        rau_pkg::FUNC_NEG: begin
                            r_rn <= -r_an;
                            r_rd <= r_ad;
                            if (r_an == {1'b1, {(W-1){1'b0}}}) r_ovf <= 1'b1;
                        end
                        rau_pkg::FUNC_INC, rau_pkg::FUNC_DEC: begin
                            r_p <= r_an;
                            r_q <= r_ad;
                        end
                        default: ;
                    endcase
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    case (r_func)
                        rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
                            r_rn <= w_sum[W-1:0];
                            if (w_sum[W] != w_sum[W-1]) r_ovf <= 1'b1;
                            r_gx <= w_sum[W-1:0];
                            r_gy <= r_rd;
                            r_state <= S_GCD;
                        end
                        rau_pkg::FUNC_INC, rau_pkg::FUNC_DEC: begin
                            r_rn <= w_sum[W-1:0];
                            r_rd <= r_ad;
                            if (w_sum[W] != w_sum[W-1]) r_ovf <= 1'b1;
                            r_state <= S_OUT;
                        end
                        rau_pkg::FUNC_CMP: begin
                            r_rn <= r_an;
                            r_rd <= r_ad;
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_gx <= r_rn;
                            r_gy <= r_rd;
                            r_state <= S_GCD;
                        end
                    endcase
                end
                S_GCD: begin
                    // gy is never zero here; remainder by -1 is zero.
                    if (r_gy == W'(-1)) begin
                        r_gx <= r_gy;
                        r_gy <= '0;
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_GWAIT;
                    end
                end
                S_GWAIT: begin
                    if (d_done) begin
                        r_gx <= r_gy;
                        r_gy <= d_rem;
                        r_state <= (d_rem == '0) ? S_DN : S_GCD;
                    end
                end
                S_DN: r_state <= S_DNW;
                S_DNW: begin
                    if (d_done) begin
                        r_rn <= d_quo;
                        if (r_gx == W'(-1) && r_rn == {1'b1, {(W-1){1'b0}}}) r_ovf <= 1'b1;
                        r_state <= S_DD;
                    end
                end
                S_DD: r_state <= S_DDW;
                S_DDW: begin
                    if (d_done) begin
                        r_rd <= d_quo;
                        if (r_gx == W'(-1) && r_rd == {1'b1, {(W-1){1'b0}}}) r_ovf <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_valid || i_ready) begin
                        r_out.res_num      <= FB'(r_rn);
                        r_out.res_den      <= FB'(r_rd);
                        r_out.a_greater    <= r_gt;
                        r_out.a_less       <= r_lt;
                        r_out.fields_equal <= (r_an == r_bn) && (r_ad == r_bd);
                        r_out.a_is_zero    <= (r_an == '0);
                        r_out.overflow     <= r_ovf;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_data  = r_out;

    // A result never claims both orderings.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.a_greater && o_data.a_less))
        else $error("a_greater and a_less both set");
    // Denominator is never zero.
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.res_den != '0))
        else $error("zero result denominator");
    // Compare passes overflow clear.
    a_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_func == rau_pkg::FUNC_CMP) |-> !r_ovf)
        else $error("overflow on compare");
    // Divider only finishes while the sequencer waits on it.
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_done |-> (r_state == S_GWAIT || r_state == S_DNW || r_state == S_DDW))
        else $error("divider done outside wait state");
endmodule
